// File: sv/igsd_pkg.sv
// Package for the IMU gesture and step detector: shared types and constants.
// No dependencies.
package igsd_pkg;
    localparam logic [2:0] REG_SHAKE_THR   = 3'd0;
    localparam logic [2:0] REG_SHAKE_N     = 3'd1;
    localparam logic [2:0] REG_TAP_THR     = 3'd2;
    localparam logic [2:0] REG_STEP_RISE   = 3'd3;
    localparam logic [2:0] REG_STEP_GAP    = 3'd4;
    localparam logic [2:0] REG_TAP_HOLD    = 3'd5;
    localparam logic [2:0] REG_SHAKE_HOLD  = 3'd6;
    localparam logic [2:0] REG_FLIP_HOLD   = 3'd7;

    localparam logic [1:0] GEST_NONE  = 2'd0;
    localparam logic [1:0] GEST_TAP   = 2'd1;
    localparam logic [1:0] GEST_SHAKE = 2'd2;
    localparam logic [1:0] GEST_FLIP  = 2'd3;

    localparam logic [15:0] ONE_G        = 16'd4096;
    localparam logic signed [15:0] FLIP_HIGH_Z = 16'sd1228;
    localparam logic signed [15:0] FLIP_LOW_Z  = -16'sd1228;
    localparam logic [15:0] FLIP_MAX_MAG = 16'd6144;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic        clear;
        logic signed [15:0] z;
        logic [31:0] now_ms;
        logic [33:0] sumsq;
    } t_req;

    typedef struct packed {
        logic [15:0] shake_thr;
        logic [3:0]  shake_n;
        logic [15:0] tap_thr;
        logic [11:0] step_rise;
        logic [15:0] step_gap;
        logic [15:0] tap_hold;
        logic [15:0] shake_hold;
        logic [15:0] flip_hold;
    } t_cfg;
endpackage

// File: sv/igsd_front.sv
// Front end: accepts requests and forms the sum of squares, one axis a cycle.
// Depends on igsd_pkg.
module igsd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [80:0]        i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output igsd_pkg::t_req     o_req
);
    import igsd_pkg::*;
    logic [1:0] r_cnt;
    logic       r_busy, r_done;
    logic signed [15:0] r_x, r_y;
    t_req r_req;
    logic signed [15:0] w_op;
    logic [31:0] w_sq;

    assign o_ready = !r_busy && !r_done;
    assign o_valid = r_done;
    assign o_req   = r_req;
    assign w_op = (r_cnt == 2'd0) ? r_x : (r_cnt == 2'd1) ? r_y : r_req.z;
    assign w_sq = 32'($signed(w_op) * $signed(w_op));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (o_ready && i_valid) begin
            r_req.clear  <= i_data[0];
            r_x          <= i_data[16:1];
            r_y          <= i_data[32:17];
            r_req.z      <= i_data[48:33];
            r_req.now_ms <= i_data[80:49];
            r_req.sumsq  <= 34'd0;
            r_busy       <= 1'b1;
            r_cnt        <= 2'd0;
        end else if (r_busy) begin
            r_req.sumsq <= r_req.sumsq + {2'b00, w_sq};
            r_cnt       <= r_cnt + 2'd1;
            if (r_cnt == 2'd2) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (r_done && i_ready) begin
            r_done <= 1'b0;
        end
    end
endmodule

// File: sv/igsd_back.sv
// Back end: square root, step filter, gesture logic and output register.
// Depends on igsd_pkg.
module igsd_back #(
    parameter int FILTER_DEPTH  = 2,
    parameter int AVERAGE_DEPTH = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  igsd_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  igsd_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [49:0]    o_data
);
    import igsd_pkg::*;
    localparam int FW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int AW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int CW = $clog2(AVERAGE_DEPTH + 1);
    localparam int FCW = $clog2(FILTER_DEPTH + 1);
    localparam int DW = (CW > FCW) ? CW : FCW;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_SQRT = 3'd1, ST_FDIV = 3'd2,
                           ST_ADIV = 3'd3, ST_DEC = 3'd4, ST_OUT = 3'd5;
    logic [2:0] r_st;
    t_req r_req;
    logic [31:0] r_v, r_res, r_bit;
    logic [15:0] r_mag, r_filt;
    logic [15:0] r_mring [FILTER_DEPTH];
    logic [15:0] r_sring [AVERAGE_DEPTH];
    logic [FW-1:0] r_mslot;
    logic [AW-1:0] r_sslot;
    logic r_mfull, r_sfull, r_above;
    logic [31:0] r_last, r_steps, r_cool;
    logic [3:0] r_run;
    logic signed [15:0] r_pz;
    logic [21:0] r_num, r_quo;
    logic [21:0] r_msum, r_ssum;
    logic [4:0] r_dcnt;
    logic [DW-1:0] r_den;
    logic [49:0] r_out;
    logic r_oval;

    logic [FW-1:0] w_mnext;
    logic [AW-1:0] w_snext;
    logic [22:0] w_rem;
    logic [32:0] w_trial;
    logic w_empty;
    logic [DW-1:0] w_cnt;

    // The ring sums are kept as running totals: the entry being replaced
    // leaves the sum and the new one joins it.
    assign w_mnext = (32'(r_mslot) == FILTER_DEPTH - 1) ? '0 : r_mslot + 1'b1;
    assign w_snext = (32'(r_sslot) == AVERAGE_DEPTH - 1) ? '0 : r_sslot + 1'b1;
    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign o_ready = (r_st == ST_IDLE) && !r_oval;
    assign o_valid = r_oval;
    assign o_data  = r_out;
    assign w_empty = (r_st == ST_FDIV) ? (!r_mfull && r_mslot == '0)
                                       : (!r_sfull && r_sslot == '0);
    assign w_cnt = (r_st == ST_FDIV) ?
        (r_mfull ? DW'(FILTER_DEPTH) : DW'(r_mslot)) :
        (r_sfull ? DW'(AVERAGE_DEPTH) : DW'(r_sslot));

    logic [16:0] w_absz;
    logic [15:0] w_filt_avg;
    logic [22:0] w_shift;
    assign w_absz = r_req.z[15] ? 17'(-$signed({r_req.z[15], r_req.z})) : 17'(r_req.z);
    assign w_shift = {r_v[21:0], r_num[21]};
    assign w_rem = w_shift - 23'(r_den);
    assign w_filt_avg = 16'(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_oval <= 1'b0;
            r_mslot <= '0; r_sslot <= '0; r_mfull <= 1'b0; r_sfull <= 1'b0;
            r_above <= 1'b0; r_last <= '0; r_steps <= '0; r_cool <= '0;
            r_run <= '0; r_pz <= 16'sd4096;
            r_msum <= '0; r_ssum <= '0;
            for (int i = 0; i < FILTER_DEPTH; i++) r_mring[i] <= '0;
            for (int i = 0; i < AVERAGE_DEPTH; i++) r_sring[i] <= '0;
        end else begin
            if (r_oval && i_ready) r_oval <= 1'b0;
            case (r_st)
                ST_IDLE: if (i_valid && !r_oval) begin
                    r_req <= i_req;
                    if (i_req.clear) begin
                        r_steps <= '0;
                        r_out <= '0;
                        r_oval <= 1'b1;
                    end else begin
                        r_v <= i_req.sumsq[31:0];
                        r_res <= '0;
                        r_bit <= 32'h4000_0000;
                        r_st <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_bit == 32'd0) begin
                        r_mag <= r_res[15:0];
                        r_mring[r_mslot] <= r_res[15:0];
                        r_msum <= r_msum - 22'(r_mring[r_mslot]) + 22'(r_res[15:0]);
                        r_mslot <= w_mnext;
                        if (w_mnext == '0) r_mfull <= 1'b1;
                        r_st <= ST_FDIV; r_dcnt <= 5'd0; r_v <= '0; r_quo <= '0;
                        r_num <= '1;
                    end else begin
                        if ({1'b0, r_v} >= w_trial) begin
                            r_v <= r_v - w_trial[31:0];
                            r_res <= (r_res >> 1) + r_bit;
                        end else r_res <= r_res >> 1;
                        r_bit <= r_bit >> 2;
                    end
                end
                ST_FDIV, ST_ADIV: begin
                    if (r_num == '1) begin
                        r_num <= (r_st == ST_FDIV) ? r_msum : r_ssum;
                        r_den <= w_empty ? '0 : w_cnt;
                        r_dcnt <= 5'd0; r_v <= '0; r_quo <= '0;
                    end else if (r_den == '0) begin
                        r_quo <= 22'(ONE_G);
                        r_dcnt <= 5'd22;
                        r_den <= DW'(1);
                        r_num <= '0;
                    end else if (r_dcnt == 5'd22) begin
                        if (r_st == ST_FDIV) begin
                            r_filt <= w_filt_avg;
                            r_sring[r_sslot] <= w_filt_avg;
                            r_ssum <= r_ssum - 22'(r_sring[r_sslot]) + 22'(w_filt_avg);
                            r_sslot <= w_snext;
                            if (w_snext == '0) r_sfull <= 1'b1;
                            r_st <= ST_ADIV; r_num <= '1;
                        end else r_st <= ST_DEC;
                    end else begin
                        if (!w_rem[22]) begin
                            r_v <= 32'(w_rem); r_quo <= {r_quo[20:0], 1'b1};
                        end else begin
                            r_v <= 32'(w_shift); r_quo <= {r_quo[20:0], 1'b0};
                        end
                        r_num <= {r_num[20:0], 1'b0};
                        r_dcnt <= r_dcnt + 5'd1;
                    end
                end
                ST_DEC: begin
                    automatic logic [31:0] avg = 32'(r_quo[15:0]);
                    automatic logic [31:0] steps = r_steps;
                    automatic logic [31:0] cool = r_cool;
                    automatic logic [1:0] g = GEST_NONE;
                    automatic logic [4:0] run = {1'b0, r_run};
                    if (!r_above && 32'(r_filt) > avg + 32'(i_cfg.step_rise))
                        r_above <= 1'b1;
                    else if (r_above && 32'(r_filt) < avg) begin
                        r_above <= 1'b0;
                        if (r_req.now_ms - r_last >= 32'(i_cfg.step_gap)) begin
                            steps = r_steps + 32'd1;
                            r_last <= r_req.now_ms;
                        end
                    end
                    r_steps <= steps;
                    if (r_req.now_ms < r_cool) r_run <= '0;
                    else if (w_absz > 17'(i_cfg.tap_thr) && r_mag > i_cfg.tap_thr) begin
                        g = GEST_TAP; cool = r_req.now_ms + 32'(i_cfg.tap_hold);
                        r_run <= '0;
                    end else begin
                        if (r_mag > i_cfg.shake_thr) begin
                            if (run < 5'd15) run = run + 5'd1;
                            if (run[3:0] >= i_cfg.shake_n) begin
                                g = GEST_SHAKE;
                                cool = r_req.now_ms + 32'(i_cfg.shake_hold);
                                run = '0;
                            end
                            r_run <= run[3:0];
                        end else r_run <= '0;
                        if (r_pz > FLIP_HIGH_Z && r_req.z < FLIP_LOW_Z &&
                            r_mag < FLIP_MAX_MAG) begin
                            g = GEST_FLIP;
                            cool = r_req.now_ms + 32'(i_cfg.flip_hold);
                        end
                    end
                    r_cool <= cool;
                    r_pz <= r_req.z;
                    r_out <= {r_mag, steps, g};
                    r_oval <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && !i_ready |=> r_oval && $stable(r_out)) else $error("output lost");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_st == ST_IDLE) else $error("ready while busy");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_IDLE && i_valid && o_ready && i_req.clear) |=> r_out == '0)
        else $error("clear result");
endmodule

// File: sv/imu_gesture_and_step_detector_unit.sv
// Top level of the IMU gesture and step detector.
// Depends on igsd_pkg, igsd_front and igsd_back.
//
// A sample request passes through these steps from acceptance to a valid
// result: the front end forms the sum of squares one axis at a time with one
// shared 16x16 multiplier, the request is handed to the back end, the
// bit-pair square root runs (sixteen steps and a closing step), two averaging
// divisions follow (each a load step, 22 restoring steps and a closing
// step), and one decision step ends it. A clear request also passes through
// the squaring front end. The front end may accept and square the next
// request while the back end still works on the previous one; each result
// is held in an output register until taken, and the back end takes no new
// request while a result waits.
module imu_gesture_and_step_detector_unit #(
    parameter int FILTER_DEPTH  = 2,
    parameter int AVERAGE_DEPTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,   // cmd
    input  logic [79:0] s_axis_tdata,   // accel_x, accel_y, accel_z, now_ms
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // gesture
    output logic [47:0] m_axis_tdata,   // steps, magnitude
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import igsd_pkg::*;
    t_cfg r_cfg;
    igsd_pkg::t_req w_req;
    logic w_fv, w_br;
    logic [49:0] w_out;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{16'd8192, 4'd3, 16'd10240, 12'd123, 16'd300, 16'd800,
                       16'd1500, 16'd2000};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHAKE_THR:  r_cfg.shake_thr  <= i_cfg_data;
                REG_SHAKE_N:    r_cfg.shake_n    <= i_cfg_data[3:0];
                REG_TAP_THR:    r_cfg.tap_thr    <= i_cfg_data;
                REG_STEP_RISE:  r_cfg.step_rise  <= i_cfg_data[11:0];
                REG_STEP_GAP:   r_cfg.step_gap   <= i_cfg_data;
                REG_TAP_HOLD:   r_cfg.tap_hold   <= i_cfg_data;
                REG_SHAKE_HOLD: r_cfg.shake_hold <= i_cfg_data;
                REG_FLIP_HOLD:  r_cfg.flip_hold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front end receives cmd in the lowest bit, then the three axes and
    // the timestamp exactly as they sit in tdata.
    igsd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data({s_axis_tdata, s_axis_tuser}),
        .o_valid(w_fv), .i_ready(w_br), .o_req(w_req)
    );

    igsd_back #(.FILTER_DEPTH(FILTER_DEPTH), .AVERAGE_DEPTH(AVERAGE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_fv), .o_ready(w_br), .i_req(w_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_out)
    );

    assign m_axis_tuser = w_out[1:0];
    assign m_axis_tdata = w_out[49:2];
endmodule
